/* src/ldts_pkg.sv */
package ldts_pkg;

    localparam int OAM_BYTES       = 160;
    localparam int DOTS_PER_LINE   = 456;
    localparam int LINES_PER_FRAME = 154;
    localparam int VISIBLE_LINES   = 144;

    localparam int SEARCH_DOTS     = 80;
    localparam int TRANSFER_DOTS   = 172;
    localparam int SHORT_LEAD_DOTS = 72;
    localparam int SHORT_TRIM_DOTS = 8;
    localparam int QUIRK_DOT       = 92;

    localparam int DOT_W      = 9;
    localparam int LINE_W     = 8;
    localparam int BLANK_W    = 17;
    localparam int DMA_TICK_W = 10;
    localparam int DMA_SLOT_W = DMA_TICK_W - 1;
    localparam int OAM_IDX_W  = 8;
    localparam int BANK_W     = 8;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam int BLANK_FRAME_TICKS = LINES_PER_FRAME * DOTS_PER_LINE;

    localparam logic [BANK_W-1:0] BANK_ECHO_A     = 8'hfe;
    localparam logic [BANK_W-1:0] BANK_ECHO_B     = 8'hff;
    localparam logic [BANK_W-1:0] BANK_ECHO_A_MAP = 8'hde;
    localparam logic [BANK_W-1:0] BANK_ECHO_B_MAP = 8'hdf;

    typedef enum logic [1:0] {
        MODE_HBLANK   = 2'd0,
        MODE_VBLANK   = 2'd1,
        MODE_SEARCH   = 2'd2,
        MODE_TRANSFER = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_DMA_START = 2'd1,
        OP_SWITCH_ON = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        REG_DISPLAY_ENABLE = 3'd0,
        REG_DOUBLE_SPEED   = 3'd1,
        REG_LINE_COMPARE   = 3'd2,
        REG_IRQ_ON_HBLANK  = 3'd3,
        REG_IRQ_ON_VBLANK  = 3'd4,
        REG_IRQ_ON_SEARCH  = 3'd5,
        REG_IRQ_ON_COMPARE = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [OAM_IDX_W-1:0] dma_oam_index;
        logic [15:0]          dma_read_addr;
        logic                 dma_read_valid;
        logic                 frame_done;
        logic                 hblank_pulse;
        logic                 vblank_irq;
        logic                 stat_irq;
        logic [DOT_W-1:0]     cur_dot;
        logic [LINE_W-1:0]    cur_line;
        logic [1:0]           cur_mode;
    } result_t;

endpackage

/* src/lcd_dot_timing_stat_dma_core.sv */
// Channel   | Dir | Signals                     | Request
// ----------+-----+-----------------------------+-------------------------------
// s_*       | in  | tvalid tready tdata tuser   | one op: dot tick, DMA start, switch-on
// m_*       | out | tvalid tready tdata         | one result per input request
// apb       | in  | psel penable pwrite paddr.. | timing and interrupt registers
//
// One request per clock while s_tready is high; the state update and the result are formed combinationally.
// The result goes to an output register, or to the skid register while the output is stalled.
// The skid register lets one request be accepted while stalled; s_tready drops while it is full.
// rst_n clears all counters, the DMA sequencer and the registers.
module lcd_dot_timing_stat_dma_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] dma_bank
    input  logic [1:0]                    s_tuser,   // [1:0] op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [1:0] cur_mode, [9:2] cur_line, [18:10] cur_dot, [19] stat_irq,
    // [20] vblank_irq, [21] hblank_pulse, [22] frame_done, [23] dma_read_valid,
    // [39:24] dma_read_addr, [47:40] dma_oam_index
    output logic [47:0]                   m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ldts_pkg::ADDR_W-1:0]   paddr,
    input  logic [ldts_pkg::DATA_W-1:0]   pwdata,
    output logic [ldts_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    logic                               display_enable_reg;
    logic                               double_speed_reg;
    logic [7:0]                         line_compare_reg;
    logic                               irq_on_hblank_reg;
    logic                               irq_on_vblank_reg;
    logic                               irq_on_search_reg;
    logic                               irq_on_compare_reg;

    logic [ldts_pkg::DOT_W-1:0]         dot_reg, dot_next;
    logic [ldts_pkg::LINE_W-1:0]        line_reg, line_next;
    ldts_pkg::mode_t                    mode_reg, mode_next;
    logic                               stat_level_reg, stat_level_next;
    logic                               short_line_reg, short_line_next;
    logic [ldts_pkg::BLANK_W-1:0]       blank_count_reg, blank_count_next;
    logic                               dma_busy_reg, dma_busy_next;
    logic [ldts_pkg::BANK_W-1:0]        dma_bank_reg, dma_bank_next;
    logic [ldts_pkg::DMA_TICK_W-1:0]    dma_tick_reg, dma_tick_next;

    ldts_pkg::result_t                  result;
    ldts_pkg::result_t                  out_data_reg;
    ldts_pkg::result_t                  skid_data_reg;
    logic                               out_valid_reg;
    logic                               skid_valid_reg;

    logic                               accept;
    logic                               cfg_write;
    ldts_pkg::reg_index_t               cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = ldts_pkg::reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_enable_reg <= 1'b0;
            double_speed_reg   <= 1'b0;
            line_compare_reg   <= '0;
            irq_on_hblank_reg  <= 1'b0;
            irq_on_vblank_reg  <= 1'b0;
            irq_on_search_reg  <= 1'b0;
            irq_on_compare_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ldts_pkg::REG_DISPLAY_ENABLE: display_enable_reg <= pwdata[0];
                ldts_pkg::REG_DOUBLE_SPEED:   double_speed_reg   <= pwdata[0];
                ldts_pkg::REG_LINE_COMPARE:   line_compare_reg   <= pwdata[7:0];
                ldts_pkg::REG_IRQ_ON_HBLANK:  irq_on_hblank_reg  <= pwdata[0];
                ldts_pkg::REG_IRQ_ON_VBLANK:  irq_on_vblank_reg  <= pwdata[0];
                ldts_pkg::REG_IRQ_ON_SEARCH:  irq_on_search_reg  <= pwdata[0];
                ldts_pkg::REG_IRQ_ON_COMPARE: irq_on_compare_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (cfg_index)
            ldts_pkg::REG_DISPLAY_ENABLE: prdata[0]   = display_enable_reg;
            ldts_pkg::REG_DOUBLE_SPEED:   prdata[0]   = double_speed_reg;
            ldts_pkg::REG_LINE_COMPARE:   prdata[7:0] = line_compare_reg;
            ldts_pkg::REG_IRQ_ON_HBLANK:  prdata[0]   = irq_on_hblank_reg;
            ldts_pkg::REG_IRQ_ON_VBLANK:  prdata[0]   = irq_on_vblank_reg;
            ldts_pkg::REG_IRQ_ON_SEARCH:  prdata[0]   = irq_on_search_reg;
            ldts_pkg::REG_IRQ_ON_COMPARE: prdata[0]   = irq_on_compare_reg;
            default: ;
        endcase
    end

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        logic                               blank_tick;
        ldts_pkg::mode_t                    mode_dot;
        ldts_pkg::mode_t                    mode_eff;
        logic [ldts_pkg::LINE_W-1:0]        line_eff;
        logic                               cond;
        logic [ldts_pkg::DOT_W-1:0]         hstart;
        logic [ldts_pkg::DOT_W-1:0]         line_end;
        logic [ldts_pkg::DOT_W-1:0]         dot_inc;
        logic [ldts_pkg::LINE_W:0]          line_inc;
        logic [ldts_pkg::BLANK_W-1:0]       blank_inc;
        logic [1:0]                         slot_low;
        logic [ldts_pkg::DMA_SLOT_W-1:0]    slot;
        logic [ldts_pkg::DMA_SLOT_W-1:0]    slot_dec;
        logic [ldts_pkg::BANK_W-1:0]        bank;

        dot_next         = dot_reg;
        line_next        = line_reg;
        mode_next        = mode_reg;
        stat_level_next  = stat_level_reg;
        short_line_next  = short_line_reg;
        blank_count_next = blank_count_reg;
        dma_busy_next    = dma_busy_reg;
        dma_bank_next    = dma_bank_reg;
        dma_tick_next    = dma_tick_reg;
        result           = '0;

        hstart   = short_line_reg
                 ? ldts_pkg::DOT_W'(ldts_pkg::SHORT_LEAD_DOTS + ldts_pkg::TRANSFER_DOTS)
                 : ldts_pkg::DOT_W'(ldts_pkg::SEARCH_DOTS + ldts_pkg::TRANSFER_DOTS);
        line_end = short_line_reg
                 ? ldts_pkg::DOT_W'(ldts_pkg::DOTS_PER_LINE - ldts_pkg::SHORT_TRIM_DOTS)
                 : ldts_pkg::DOT_W'(ldts_pkg::DOTS_PER_LINE);
        dot_inc   = dot_reg + 1'b1;
        line_inc  = {1'b0, line_reg} + 1'b1;
        blank_inc = blank_count_reg + 1'b1;

        if (short_line_reg)
        begin
            if (dot_reg < ldts_pkg::DOT_W'(ldts_pkg::SHORT_LEAD_DOTS))
                mode_dot = ldts_pkg::MODE_HBLANK;
            else if (dot_reg < hstart)
                mode_dot = ldts_pkg::MODE_TRANSFER;
            else
                mode_dot = ldts_pkg::MODE_HBLANK;
        end
        else if (line_reg < ldts_pkg::LINE_W'(ldts_pkg::VISIBLE_LINES))
        begin
            if (dot_reg < ldts_pkg::DOT_W'(ldts_pkg::SEARCH_DOTS))
                mode_dot = ldts_pkg::MODE_SEARCH;
            else if (dot_reg < hstart)
                mode_dot = ldts_pkg::MODE_TRANSFER;
            else
                mode_dot = ldts_pkg::MODE_HBLANK;
        end
        else
        begin
            mode_dot = ldts_pkg::MODE_VBLANK;
        end

        blank_tick = (blank_count_reg != '0) || ((dot_reg == '0) && !display_enable_reg);
        mode_eff   = blank_tick ? mode_reg : mode_dot;

        // last line reads as line zero from the quirk dot on
        if ((line_reg == ldts_pkg::LINE_W'(ldts_pkg::LINES_PER_FRAME - 1))
            && (dot_reg >= ldts_pkg::DOT_W'(ldts_pkg::QUIRK_DOT)))
            line_eff = '0;
        else
            line_eff = line_reg;

        cond = (irq_on_hblank_reg && (mode_eff == ldts_pkg::MODE_HBLANK))
            || (irq_on_vblank_reg && (mode_eff == ldts_pkg::MODE_VBLANK))
            || (irq_on_search_reg && (mode_eff == ldts_pkg::MODE_SEARCH))
            || (irq_on_compare_reg && (line_eff == line_compare_reg));

        if (double_speed_reg)
        begin
            slot_low = {1'b0, dma_tick_reg[0]};
            slot     = dma_tick_reg[ldts_pkg::DMA_TICK_W-1:1];
        end
        else
        begin
            slot_low = dma_tick_reg[1:0];
            slot     = {1'b0, dma_tick_reg[ldts_pkg::DMA_TICK_W-1:2]};
        end
        slot_dec = slot - 1'b1;

        if (dma_bank_reg == ldts_pkg::BANK_ECHO_A)
            bank = ldts_pkg::BANK_ECHO_A_MAP;
        else if (dma_bank_reg == ldts_pkg::BANK_ECHO_B)
            bank = ldts_pkg::BANK_ECHO_B_MAP;
        else
            bank = dma_bank_reg;

        if (accept)
        begin
            unique case (ldts_pkg::op_t'(s_tuser))
                ldts_pkg::OP_TICK:
                begin
                    stat_level_next = cond;
                    result.stat_irq = cond && !stat_level_reg;

                    if (dma_busy_reg)
                    begin
                        dma_tick_next = dma_tick_reg + 1'b1;
                        if ((slot_low == '0) && (slot != '0))
                        begin
                            if (slot == ldts_pkg::DMA_SLOT_W'(ldts_pkg::OAM_BYTES + 1))
                            begin
                                dma_busy_next = 1'b0;
                            end
                            else if (slot <= ldts_pkg::DMA_SLOT_W'(ldts_pkg::OAM_BYTES))
                            begin
                                result.dma_read_valid = 1'b1;
                                result.dma_read_addr  = {bank, slot_dec[7:0]};
                                result.dma_oam_index  = slot_dec[ldts_pkg::OAM_IDX_W-1:0];
                            end
                        end
                    end

                    if (blank_tick)
                    begin
                        blank_count_next = blank_inc;
                        if (blank_inc >= ldts_pkg::BLANK_W'(ldts_pkg::BLANK_FRAME_TICKS))
                        begin
                            blank_count_next  = '0;
                            result.frame_done = 1'b1;
                        end
                    end
                    else
                    begin
                        mode_next           = mode_dot;
                        result.hblank_pulse = (mode_dot == ldts_pkg::MODE_HBLANK)
                                           && (dot_reg == hstart);
                        if (dot_inc >= line_end)
                        begin
                            dot_next        = '0;
                            short_line_next = 1'b0;
                            if (line_inc == (ldts_pkg::LINE_W + 1)'(ldts_pkg::VISIBLE_LINES))
                            begin
                                result.vblank_irq = 1'b1;
                                result.frame_done = 1'b1;
                            end
                            if (line_inc >= (ldts_pkg::LINE_W + 1)'(ldts_pkg::LINES_PER_FRAME))
                                line_next = '0;
                            else
                                line_next = line_inc[ldts_pkg::LINE_W-1:0];
                        end
                        else
                        begin
                            dot_next = dot_inc;
                        end
                    end
                end
                ldts_pkg::OP_DMA_START:
                begin
                    dma_busy_next = 1'b1;
                    dma_tick_next = '0;
                    dma_bank_next = s_tdata;
                end
                ldts_pkg::OP_SWITCH_ON:
                begin
                    short_line_next  = 1'b1;
                    dot_next         = '0;
                    line_next        = '0;
                    mode_next        = ldts_pkg::MODE_HBLANK;
                    blank_count_next = '0;
                end
                default: ;
            endcase
        end

        result.cur_mode = mode_next;
        result.cur_line = line_next;
        result.cur_dot  = (ldts_pkg::op_t'(s_tuser) == ldts_pkg::OP_SWITCH_ON) ? '0 : dot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg         <= '0;
            line_reg        <= '0;
            mode_reg        <= ldts_pkg::MODE_HBLANK;
            stat_level_reg  <= 1'b0;
            short_line_reg  <= 1'b0;
            blank_count_reg <= '0;
            dma_busy_reg    <= 1'b0;
            dma_bank_reg    <= '0;
            dma_tick_reg    <= '0;
        end
        else
        begin
            dot_reg         <= dot_next;
            line_reg        <= line_next;
            mode_reg        <= mode_next;
            stat_level_reg  <= stat_level_next;
            short_line_reg  <= short_line_next;
            blank_count_reg <= blank_count_next;
            dma_busy_reg    <= dma_busy_next;
            dma_bank_reg    <= dma_bank_next;
            dma_tick_reg    <= dma_tick_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (m_tready || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (m_tready || !out_valid_reg)
            out_data_reg <= skid_valid_reg ? skid_data_reg : result;
        else if (accept)
            skid_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_line_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg < ldts_pkg::LINE_W'(ldts_pkg::LINES_PER_FRAME))
        else $error("line counter past end of frame");

    a_dma_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.dma_read_valid) |-> dma_busy_reg)
        else $error("DMA copy while sequencer idle");

    a_blank_holds_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (blank_count_reg != '0) |-> (dot_reg == '0))
        else $error("dot counter moved during blank frame");

endmodule

/* tb/lcd_dot_timing_stat_dma_core_test.sv */
`timescale 1ns / 1ps

module lcd_dot_timing_stat_dma_core_test;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int REPORT_LIMIT = 100;
    localparam int FILL_ZERO = 0;
    localparam int FILL_ONES = 1;
    localparam int FILL_RANDOM = 2;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata = '0;   // [7:0] dma_bank
    logic [1:0]                    s_tuser = '0;   // [1:0] op
    logic                          m_tvalid;
    logic                          m_tready = 1'b1;
    // [1:0] cur_mode, [9:2] cur_line, [18:10] cur_dot, [19] stat_irq,
    // [20] vblank_irq, [21] hblank_pulse, [22] frame_done, [23] dma_read_valid,
    // [39:24] dma_read_addr, [47:40] dma_oam_index
    logic [47:0]                   m_tdata;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [ldts_pkg::ADDR_W-1:0]   paddr = '0;
    logic [ldts_pkg::DATA_W-1:0]   pwdata = '0;
    logic [ldts_pkg::DATA_W-1:0]   prdata;
    logic                          pready;

    logic              disp_on = 1'b0;
    logic              fast_dma = 1'b0;
    logic [7:0]        compare_line = '0;
    logic              irq_hblank_en = 1'b0;
    logic              irq_vblank_en = 1'b0;
    logic              irq_search_en = 1'b0;
    logic              irq_compare_en = 1'b0;

    logic [ldts_pkg::DOT_W-1:0]      dot_pos = '0;
    logic [ldts_pkg::LINE_W-1:0]     line_pos = '0;
    ldts_pkg::mode_t                 mode_now = ldts_pkg::MODE_HBLANK;
    logic                            stat_line = 1'b0;
    logic                            short_line = 1'b0;
    logic [ldts_pkg::BLANK_W-1:0]    blank_ticks = '0;
    logic                            dma_active = 1'b0;
    logic [ldts_pkg::BANK_W-1:0]     dma_src_bank = '0;
    logic [ldts_pkg::DMA_TICK_W-1:0] dma_ticks = '0;

    ldts_pkg::result_t pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      results_seen = 0;
    int      frames_seen = 0;
    int      dma_bytes_seen = 0;
    int      stat_irqs_seen = 0;
    bit      idle_on = 1'b1;
    logic [2:0] ready_hold = '0;

    lcd_dot_timing_stat_dma_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic ldts_pkg::mode_t mode_at(logic [ldts_pkg::DOT_W-1:0] dot);
        if (short_line)
        begin
            if (dot >= ldts_pkg::SHORT_LEAD_DOTS
                && dot < ldts_pkg::SHORT_LEAD_DOTS + ldts_pkg::TRANSFER_DOTS)
                return ldts_pkg::MODE_TRANSFER;
            return ldts_pkg::MODE_HBLANK;
        end
        if (line_pos >= ldts_pkg::VISIBLE_LINES)
            return ldts_pkg::MODE_VBLANK;
        if (dot < ldts_pkg::SEARCH_DOTS)
            return ldts_pkg::MODE_SEARCH;
        if (dot < ldts_pkg::SEARCH_DOTS + ldts_pkg::TRANSFER_DOTS)
            return ldts_pkg::MODE_TRANSFER;
        return ldts_pkg::MODE_HBLANK;
    endfunction

    function automatic logic stat_rise();
        logic [ldts_pkg::LINE_W-1:0] ly;
        logic                        level;
        logic                        rise;
        ly = (line_pos == ldts_pkg::LINES_PER_FRAME - 1 && dot_pos >= ldts_pkg::QUIRK_DOT)
           ? '0 : line_pos;
        level = (irq_hblank_en && mode_now == ldts_pkg::MODE_HBLANK)
             || (irq_vblank_en && mode_now == ldts_pkg::MODE_VBLANK)
             || (irq_search_en && mode_now == ldts_pkg::MODE_SEARCH)
             || (irq_compare_en && ly == compare_line);
        rise = level && !stat_line;
        stat_line = level;
        return rise;
    endfunction

    function automatic void dma_step(inout ldts_pkg::result_t r);
        int                          slot;
        logic [ldts_pkg::BANK_W-1:0] src;
        if (!dma_active)
            return;
        slot = int'(dma_ticks);
        dma_ticks = dma_ticks + 1'b1;
        if ((slot & (fast_dma ? 1 : 3)) != 0)
            return;
        slot = fast_dma ? slot >> 1 : slot >> 2;
        if (slot == 0)
            return;
        if (slot == ldts_pkg::OAM_BYTES + 1)
            dma_active = 1'b0;
        else if (slot <= ldts_pkg::OAM_BYTES)
        begin
            src = dma_src_bank;
            if (src == ldts_pkg::BANK_ECHO_A)
                src = ldts_pkg::BANK_ECHO_A_MAP;
            else if (src == ldts_pkg::BANK_ECHO_B)
                src = ldts_pkg::BANK_ECHO_B_MAP;
            r.dma_read_valid = 1'b1;
            r.dma_read_addr = {src, 8'(slot - 1)};
            r.dma_oam_index = ldts_pkg::OAM_IDX_W'(slot - 1);
        end
    endfunction

    function automatic ldts_pkg::result_t predict_result(logic [1:0] op, logic [7:0] bank);
        ldts_pkg::result_t          r;
        logic [ldts_pkg::DOT_W-1:0] dot_in;
        int                         hstart;
        int                         line_end;
        r = '0;
        dot_in = dot_pos;
        if (op == ldts_pkg::OP_TICK)
        begin
            if (blank_ticks != 0 || (dot_pos == 0 && !disp_on))
            begin
                r.stat_irq = stat_rise();
                dma_step(r);
                blank_ticks = blank_ticks + 1'b1;
                if (blank_ticks >= ldts_pkg::BLANK_FRAME_TICKS)
                begin
                    blank_ticks = '0;
                    r.frame_done = 1'b1;
                end
            end
            else
            begin
                hstart = short_line ? ldts_pkg::SHORT_LEAD_DOTS + ldts_pkg::TRANSFER_DOTS
                                    : ldts_pkg::SEARCH_DOTS + ldts_pkg::TRANSFER_DOTS;
                line_end = short_line ? ldts_pkg::DOTS_PER_LINE - ldts_pkg::SHORT_TRIM_DOTS
                                      : ldts_pkg::DOTS_PER_LINE;
                mode_now = mode_at(dot_pos);
                r.hblank_pulse = (mode_now == ldts_pkg::MODE_HBLANK) && (dot_pos == hstart);
                r.stat_irq = stat_rise();
                dma_step(r);
                if (dot_pos + 1 >= line_end)
                begin
                    dot_pos = '0;
                    short_line = 1'b0;
                    if (line_pos + 1 == ldts_pkg::VISIBLE_LINES)
                    begin
                        r.vblank_irq = 1'b1;
                        r.frame_done = 1'b1;
                    end
                    line_pos = (line_pos + 1 >= ldts_pkg::LINES_PER_FRAME)
                             ? '0 : line_pos + 1'b1;
                end
                else
                    dot_pos = dot_pos + 1'b1;
            end
        end
        else if (op == ldts_pkg::OP_DMA_START)
        begin
            dma_active = 1'b1;
            dma_ticks = '0;
            dma_src_bank = bank;
        end
        else if (op == ldts_pkg::OP_SWITCH_ON)
        begin
            short_line = 1'b1;
            dot_pos = '0;
            line_pos = '0;
            mode_now = ldts_pkg::MODE_HBLANK;
            blank_ticks = '0;
            dot_in = '0;
        end
        r.cur_mode = mode_now;
        r.cur_line = line_pos;
        r.cur_dot = dot_in;
        return r;
    endfunction

    function automatic logic [ldts_pkg::DATA_W-1:0] reg_mirror(ldts_pkg::reg_index_t idx);
        case (idx)
            ldts_pkg::REG_DISPLAY_ENABLE: return ldts_pkg::DATA_W'(disp_on);
            ldts_pkg::REG_DOUBLE_SPEED:   return ldts_pkg::DATA_W'(fast_dma);
            ldts_pkg::REG_LINE_COMPARE:   return ldts_pkg::DATA_W'(compare_line);
            ldts_pkg::REG_IRQ_ON_HBLANK:  return ldts_pkg::DATA_W'(irq_hblank_en);
            ldts_pkg::REG_IRQ_ON_VBLANK:  return ldts_pkg::DATA_W'(irq_vblank_en);
            ldts_pkg::REG_IRQ_ON_SEARCH:  return ldts_pkg::DATA_W'(irq_search_en);
            ldts_pkg::REG_IRQ_ON_COMPARE: return ldts_pkg::DATA_W'(irq_compare_en);
            default:                      return '0;
        endcase
    endfunction

    task automatic report_error(string what, logic [47:0] want, logic [47:0] seen);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s expected %0h, got %0h", $time, what, want, seen);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] seen);
        if (seen !== want)
            report_error(name, 48'(want), 48'(seen));
    endtask

    always @(posedge clk)
    begin : check_results
        ldts_pkg::result_t want;
        ldts_pkg::result_t seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen = m_tdata;
            if (pending_results.size() == 0)
                report_error("result with no request pending", '0, m_tdata);
            else
            begin
                want = pending_results.pop_front();
                check_field("cur_mode", 16'(want.cur_mode), 16'(seen.cur_mode));
                check_field("cur_line", 16'(want.cur_line), 16'(seen.cur_line));
                check_field("cur_dot", 16'(want.cur_dot), 16'(seen.cur_dot));
                check_field("stat_irq", 16'(want.stat_irq), 16'(seen.stat_irq));
                check_field("vblank_irq", 16'(want.vblank_irq), 16'(seen.vblank_irq));
                check_field("hblank_pulse", 16'(want.hblank_pulse), 16'(seen.hblank_pulse));
                check_field("frame_done", 16'(want.frame_done), 16'(seen.frame_done));
                check_field("dma_read_valid", 16'(want.dma_read_valid),
                            16'(seen.dma_read_valid));
                check_field("dma_read_addr", want.dma_read_addr, seen.dma_read_addr);
                check_field("dma_oam_index", 16'(want.dma_oam_index),
                            16'(seen.dma_oam_index));
                results_seen++;
                frames_seen += int'(want.frame_done);
                dma_bytes_seen += int'(want.dma_read_valid);
                stat_irqs_seen += int'(want.stat_irq);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!idle_on)
            m_tready <= 1'b1;
        else if (ready_hold != 0)
        begin
            ready_hold <= ready_hold - 1'b1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            ready_hold <= 3'($urandom_range(0, 4));
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("lcd_dot_timing_stat_dma_core_test: errors");
            $finish;
        end
    end

    task automatic push_request(logic [1:0] op, logic [7:0] bank);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= bank;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(predict_result(op, bank));
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic run_ticks(int count, bit sprinkle);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 4095);
            if (sprinkle && pick == 0)
                push_request(ldts_pkg::OP_DMA_START, 8'($urandom));
            else if (sprinkle && pick == 1)
                push_request(OP_RESERVED, 8'($urandom));
            else
                push_request(ldts_pkg::OP_TICK, 8'($urandom));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_reg(ldts_pkg::reg_index_t idx, logic [ldts_pkg::DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ldts_pkg::REG_DISPLAY_ENABLE: disp_on = value[0];
            ldts_pkg::REG_DOUBLE_SPEED:   fast_dma = value[0];
            ldts_pkg::REG_LINE_COMPARE:   compare_line = value[7:0];
            ldts_pkg::REG_IRQ_ON_HBLANK:  irq_hblank_en = value[0];
            ldts_pkg::REG_IRQ_ON_VBLANK:  irq_vblank_en = value[0];
            ldts_pkg::REG_IRQ_ON_SEARCH:  irq_search_en = value[0];
            ldts_pkg::REG_IRQ_ON_COMPARE: irq_compare_en = value[0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic check_reg(ldts_pkg::reg_index_t idx);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== reg_mirror(idx))
            report_error($sformatf("register %s read", idx.name()),
                         48'(reg_mirror(idx)), 48'(prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all_regs(int fill);
        logic [ldts_pkg::DATA_W-1:0] value;
        for (int i = 0; i <= int'(ldts_pkg::REG_IRQ_ON_COMPARE); i++)
        begin
            case (fill)
                FILL_ZERO: value = '0;
                FILL_ONES: value = '1;
                default:   value = $urandom;
            endcase
            set_reg(ldts_pkg::reg_index_t'(i), value);
        end
    endtask

    task automatic test_register_access();
        write_all_regs(FILL_RANDOM);
        for (int i = 0; i <= int'(ldts_pkg::REG_IRQ_ON_COMPARE); i++)
            check_reg(ldts_pkg::reg_index_t'(i));
        write_all_regs(FILL_ONES);
        for (int i = 0; i <= int'(ldts_pkg::REG_IRQ_ON_COMPARE); i++)
            check_reg(ldts_pkg::reg_index_t'(i));
        write_all_regs(FILL_ZERO);
        for (int i = 0; i <= int'(ldts_pkg::REG_IRQ_ON_COMPARE); i++)
            check_reg(ldts_pkg::reg_index_t'(i));
    endtask

    task automatic test_directed_ops();
        write_all_regs(FILL_ONES);
        set_reg(ldts_pkg::REG_DOUBLE_SPEED, '0);
        set_reg(ldts_pkg::REG_LINE_COMPARE, '0);
        push_request(ldts_pkg::OP_SWITCH_ON, 8'h00);
        run_ticks(3, 1'b0);
        push_request(ldts_pkg::OP_DMA_START, ldts_pkg::BANK_ECHO_A);
        run_ticks(5, 1'b0);
        push_request(ldts_pkg::OP_DMA_START, ldts_pkg::BANK_ECHO_B);
        run_ticks(5, 1'b0);
        push_request(OP_RESERVED, 8'hff);
        push_request(ldts_pkg::OP_DMA_START, 8'h00);
        push_request(OP_RESERVED, 8'h00);
        push_request(ldts_pkg::OP_SWITCH_ON, 8'hff);
        push_request(ldts_pkg::OP_DMA_START, 8'h5a);
        run_ticks(2, 1'b0);
        push_request(ldts_pkg::OP_DMA_START, 8'ha5);
        run_ticks(1, 1'b0);
    endtask

    task automatic test_dma_transfer();
        drain();
        set_reg(ldts_pkg::REG_DOUBLE_SPEED, 32'd1);
        push_request(ldts_pkg::OP_DMA_START, ldts_pkg::BANK_ECHO_B);
        run_ticks(330, 1'b0);
        drain();
        set_reg(ldts_pkg::REG_DOUBLE_SPEED, '0);
        push_request(ldts_pkg::OP_DMA_START, ldts_pkg::BANK_ECHO_A);
        run_ticks(340, 1'b0);
        drain();
        // switch speed mid-transfer: slots land past the end and copy nothing
        set_reg(ldts_pkg::REG_DOUBLE_SPEED, 32'd1);
        run_ticks(20, 1'b0);
    endtask

    task automatic test_line_timing();
        drain();
        write_all_regs(FILL_ZERO);
        set_reg(ldts_pkg::REG_DISPLAY_ENABLE, 32'd1);
        set_reg(ldts_pkg::REG_IRQ_ON_HBLANK, 32'd1);
        set_reg(ldts_pkg::REG_IRQ_ON_VBLANK, 32'd1);
        set_reg(ldts_pkg::REG_IRQ_ON_SEARCH, 32'd1);
        set_reg(ldts_pkg::REG_IRQ_ON_COMPARE, 32'd1);
        set_reg(ldts_pkg::REG_LINE_COMPARE, 32'd1);
        run_ticks(230, 1'b1);
    endtask

    task automatic test_blank_frames();
        drain();
        set_reg(ldts_pkg::REG_DISPLAY_ENABLE, '0);
        set_reg(ldts_pkg::REG_DOUBLE_SPEED, '0);
        push_request(ldts_pkg::OP_SWITCH_ON, 8'($urandom));
        run_ticks(50, 1'b1);
        drain();
        set_reg(ldts_pkg::REG_DISPLAY_ENABLE, 32'd1);
        run_ticks(40, 1'b1);
        push_request(ldts_pkg::OP_SWITCH_ON, 8'($urandom));
        run_ticks(50, 1'b1);
    endtask

    task automatic test_random_mix();
        int pick;
        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            if (phase == 3)
                idle_on = 1'b0;
            write_all_regs(phase == 0 ? FILL_ONES : phase == 1 ? FILL_ZERO : FILL_RANDOM);
            for (int i = 0; i < 40; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 85)
                    push_request(ldts_pkg::OP_TICK, 8'($urandom));
                else if (pick < 93)
                    push_request(ldts_pkg::OP_DMA_START, 8'($urandom));
                else if (pick < 96)
                    push_request(ldts_pkg::OP_SWITCH_ON, 8'($urandom));
                else
                    push_request(OP_RESERVED, 8'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_ops();
        test_dma_transfer();
        test_line_timing();
        test_blank_frames();
        test_random_mix();
        drain();
        repeat (8) @(posedge clk);
        $display("checked %0d results: %0d frame ends, %0d DMA bytes, %0d status interrupts",
                 results_seen, frames_seen, dma_bytes_seen, stat_irqs_seen);
        $display("covered register access, DMA remap and speed change, short and full lines,");
        $display("blank frames and random ops");
        if (error_count == 0)
            $display("lcd_dot_timing_stat_dma_core_test: clean");
        else
            $display("lcd_dot_timing_stat_dma_core_test: errors");
        $finish;
    end

endmodule
